// ===== hw/rtl/rose_curve_segment_generator_macros.svh =====
// Assertion macros shared by the checker of the rose curve segment generator
`ifndef ROSE_CURVE_SEGMENT_GENERATOR_MACROS_SVH
`define ROSE_CURVE_SEGMENT_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RCSG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rcsg assertion failed");

// next-cycle implication, disabled while in reset
`define RCSG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rcsg assertion failed");

`endif

// ===== hw/rtl/rcsg_pkg.sv =====
// Types, constants and tables of the rose curve segment generator
package rcsg_pkg;

  // register indexes
  localparam logic [2:0] REG_PETAL_N    = 3'd0;
  localparam logic [2:0] REG_PETAL_D    = 3'd1;
  localparam logic [2:0] REG_CURVE_SIZE = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X   = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd4;
  localparam logic [2:0] REG_STEP_TURNS = 3'd5;

  // register reset values
  localparam logic [4:0]  RST_PETAL_N    = 5'd1;
  localparam logic [4:0]  RST_PETAL_D    = 5'd1;
  localparam logic [9:0]  RST_CURVE_SIZE = 10'd256;
  localparam logic [9:0]  RST_ORIGIN_X   = 10'd320;
  localparam logic [9:0]  RST_ORIGIN_Y   = 10'd240;
  localparam logic [19:0] RST_STEP_TURNS = 20'd73014;

  // 64*pi in Q32, segment count limit, CORDIC gain in Q30
  localparam logic [39:0] SIXTYFOUR_PI_Q32 = 40'd863554413089;
  localparam logic [11:0] LAST_INDEX_MAX   = 12'd4095;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam int unsigned ATAN_LEN = 24;

  typedef struct packed {
    logic [4:0]  petal_n;
    logic [4:0]  petal_d;
    logic [9:0]  curve_size;
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [19:0] step_turns;
  } cfg_t;

  // one queued segment request
  typedef struct packed {
    logic [11:0] k;
    logic [15:0] rotation;
    logic        last;
  } seg_t;

  // denominator with zero read as one
  function automatic logic [4:0] denom(input logic [4:0] d);
    return (d == 5'd0) ? 5'd1 : d;
  endfunction

  // atan(2^-i) in turns, Q32
  function automatic logic [31:0] atan_q32(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/rcsg_front.sv =====
// Front end: accepts requests, keeps the segment counter, flags the last segment
module rcsg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rcsg_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       rotation_i,
  input  logic              restart_i,
  input  logic              full_i,
  output logic              push_o,
  output rcsg_pkg::seg_t    push_data_o
);

  logic [11:0] seg_q, seg_d;
  logic [44:0] span_prod;
  logic [12:0] span;
  logic [11:0] last_idx;
  logic [11:0] k;
  logic        is_last;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  // final index of a pass: floor(d * 64 pi), clamped to the counter range
  assign span_prod = 45'(rcsg_pkg::denom(cfg_i.petal_d)) * 45'(rcsg_pkg::SIXTYFOUR_PI_Q32);
  assign span      = span_prod[44:32];
  assign last_idx  = (span > 13'(rcsg_pkg::LAST_INDEX_MAX)) ? rcsg_pkg::LAST_INDEX_MAX
                                                            : span[11:0];

  // classify the word
  assign k       = restart_i ? 12'd0 : seg_q;
  assign is_last = (k >= last_idx);
  assign seg_d   = is_last ? 12'd0 : (k + 12'd1);

  assign push_data_o.k        = k;
  assign push_data_o.rotation = rotation_i;
  assign push_data_o.last     = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= 12'd0;
    end else if (push_o) begin
      seg_q <= seg_d;
    end
  end

endmodule

// ===== hw/rtl/rcsg_queue.sv =====
// Two-entry queue between the front and back ends
module rcsg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcsg_pkg::seg_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output rcsg_pkg::seg_t pop_data_o,
  output logic           empty_o
);

  rcsg_pkg::seg_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/rcsg_cordic.sv =====
// Iterative CORDIC: sine and cosine in Q1.15 of an angle in turns
module rcsg_cordic #(
  parameter int unsigned ANGLE_FRACTION_BITS = 16,
  parameter int unsigned CORDIC_ITERATIONS   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ANGLE_FRACTION_BITS-1:0] angle_i,
  output logic                           done_o,
  output logic signed [15:0]             cos_o,
  output logic signed [15:0]             sin_o
);

  localparam int unsigned NIT = (CORDIC_ITERATIONS < rcsg_pkg::ATAN_LEN) ?
                                CORDIC_ITERATIONS : rcsg_pkg::ATAN_LEN;

  logic               run_q, done_q;
  logic [4:0]         iter_q;
  logic [1:0]         quad_q;
  logic signed [33:0] x_q, y_q, dx, dy;
  logic signed [32:0] z_q, atan_v;
  logic [31:0]        a32, z32;
  logic [1:0]         quad;
  logic signed [15:0] c, s;

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32767) return 16'sd32767;
    if (t < -34'sd32768) return -16'sd32768;
    return t[15:0];
  endfunction

  // nearest quadrant removed from the angle
  assign a32  = 32'(angle_i) << (32 - ANGLE_FRACTION_BITS);
  assign quad = 2'((a32 + 32'h2000_0000) >> 30);
  assign z32  = a32 - {quad, 30'd0};

  assign dx     = y_q >>> iter_q;
  assign dy     = x_q >>> iter_q;
  assign atan_v = $signed({1'b0, rcsg_pkg::atan_q32(iter_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        iter_q <= 5'd0;
      end else if (run_q) begin
        iter_q <= iter_q + 5'd1;
        if (iter_q == 5'(NIT - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // rotation datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rcsg_pkg::CORDIC_GAIN_Q30;
      y_q    <= 34'sd0;
      z_q    <= 33'(signed'(z32));
      quad_q <= quad;
    end else if (run_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atan_v;
      end
    end
  end

  // fold back the quadrant
  assign c = to_q15(x_q);
  assign s = to_q15(y_q);

  always_comb begin
    case (quad_q)
      2'd0: begin cos_o = c;  sin_o = s;  end
      2'd1: begin cos_o = -s; sin_o = c;  end
      2'd2: begin cos_o = -c; sin_o = -s; end
      default: begin cos_o = s; sin_o = -c; end
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== hw/rtl/rcsg_back.sv =====
// Back end: computes both endpoints of a segment and holds the result word
module rcsg_back #(
  parameter int unsigned ANGLE_FRACTION_BITS = 16,
  parameter int unsigned CORDIC_ITERATIONS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rcsg_pkg::cfg_t        cfg_i,
  input  logic                  empty_i,
  input  rcsg_pkg::seg_t        entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [11:0]    start_x_o,
  output logic signed [11:0]    start_y_o,
  output logic signed [11:0]    end_x_o,
  output logic signed [11:0]    end_y_o,
  output logic                  last_o
);

  localparam int unsigned AFB = ANGLE_FRACTION_BITS;
  localparam int unsigned DVW = 38;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_MUL2 = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_RAD  = 4'd4;
  localparam logic [3:0] ST_RADW = 4'd5;
  localparam logic [3:0] ST_ANG  = 4'd6;
  localparam logic [3:0] ST_ANGW = 4'd7;
  localparam logic [3:0] ST_PIX1 = 4'd8;
  localparam logic [3:0] ST_PIX2 = 4'd9;
  localparam logic [3:0] ST_PIX3 = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0]          st_q, st_d;
  logic                pt_q;
  logic [11:0]         k_q;
  logic [15:0]         rot_q;
  logic                last_q;
  logic [17:0]         prod1_q;
  logic [32:0]         angp_q;
  logic [DVW-1:0]      dvd_q;
  logic [AFB-1:0]      ang_q, quo_q;
  logic [4:0]          rem_q;
  logic [5:0]          cnt_q;
  logic [5:0]          trial;
  logic [4:0]          dvs;
  logic [12:0]         kp;
  logic signed [15:0]  rs_q, c_q, s_q;
  logic signed [31:0]  m1_q, m2_q;
  logic signed [42:0]  p1_q, p2_q, rx, ry;
  logic [11:0]         px, py;
  logic [11:0]         sx_q, sy_q, ex_q, ey_q;
  logic                out_free, load_out;
  logic                cor_start, cor_done;
  logic [AFB-1:0]      cor_angle;
  logic signed [15:0]  cor_cos, cor_sin;

  rcsg_cordic #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
    .CORDIC_ITERATIONS   (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  assign cor_start = (st_q == ST_RAD) || (st_q == ST_ANG);
  assign cor_angle = (st_q == ST_RAD) ? quo_q : ang_q;

  assign kp    = {1'b0, k_q} + {12'd0, pt_q};
  assign dvs   = rcsg_pkg::denom(cfg_i.petal_d);
  assign trial = {rem_q, dvd_q[DVW-1]};

  assign out_free = !out_valid_o || !out_stall_i;
  assign load_out = (st_q == ST_OUT) && out_free;
  assign pop_o    = (st_q == ST_IDLE) && !empty_i;

  // pixel rounding, halves toward plus infinity
  assign rx = (p1_q + 43'sd536870912) >>> 30;
  assign ry = (p2_q + 43'sd536870912) >>> 30;
  assign px = rx[11:0] + {2'd0, cfg_i.origin_x};
  assign py = ry[11:0] + {2'd0, cfg_i.origin_y};

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (!empty_i) st_d = ST_MUL1;
      ST_MUL1: st_d = ST_MUL2;
      ST_MUL2: st_d = ST_DIV;
      ST_DIV:  if (cnt_q == 6'd1) st_d = ST_RAD;
      ST_RAD:  st_d = ST_RADW;
      ST_RADW: if (cor_done) st_d = ST_ANG;
      ST_ANG:  st_d = ST_ANGW;
      ST_ANGW: if (cor_done) st_d = ST_PIX1;
      ST_PIX1: st_d = ST_PIX2;
      ST_PIX2: st_d = ST_PIX3;
      ST_PIX3: st_d = pt_q ? ST_OUT : ST_MUL1;
      ST_OUT:  if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pt_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (pop_o) pt_q <= 1'b0;
      else if (st_q == ST_PIX3) pt_q <= 1'b1;
      if (load_out) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      k_q    <= entry_i.k;
      rot_q  <= entry_i.rotation;
      last_q <= entry_i.last;
    end
    if (st_q == ST_MUL1) begin
      prod1_q <= 18'(cfg_i.petal_n) * 18'(kp);
      angp_q  <= 33'(kp) * 33'(cfg_i.step_turns);
    end
    if (st_q == ST_MUL2) begin
      dvd_q <= DVW'(prod1_q) * DVW'(cfg_i.step_turns);
      ang_q <= AFB'(angp_q + 33'(rot_q));
      rem_q <= 5'd0;
      quo_q <= '0;
      cnt_q <= 6'(DVW);
    end
    // restoring division, one quotient bit per cycle
    if (st_q == ST_DIV) begin
      if (trial >= {1'b0, dvs}) begin
        rem_q <= 5'(trial - {1'b0, dvs});
        quo_q <= {quo_q[AFB-2:0], 1'b1};
      end else begin
        rem_q <= trial[4:0];
        quo_q <= {quo_q[AFB-2:0], 1'b0};
      end
      dvd_q <= {dvd_q[DVW-2:0], 1'b0};
      cnt_q <= cnt_q - 6'd1;
    end
    if (st_q == ST_RADW && cor_done) rs_q <= cor_sin;
    if (st_q == ST_ANGW && cor_done) begin
      c_q <= cor_cos;
      s_q <= cor_sin;
    end
    if (st_q == ST_PIX1) begin
      m1_q <= rs_q * c_q;
      m2_q <= rs_q * s_q;
    end
    if (st_q == ST_PIX2) begin
      p1_q <= m1_q * $signed({1'b0, cfg_i.curve_size});
      p2_q <= m2_q * $signed({1'b0, cfg_i.curve_size});
    end
    if (st_q == ST_PIX3 && !pt_q) begin
      sx_q <= px;
      sy_q <= py;
    end
    // end point waits here so a stalled word keeps its payload
    if (st_q == ST_PIX3 && pt_q) begin
      ex_q <= px;
      ey_q <= py;
    end
    if (load_out) begin
      start_x_o <= sx_q;
      start_y_o <= sy_q;
      end_x_o   <= ex_q;
      end_y_o   <= ey_q;
      last_o    <= last_q;
    end
  end

endmodule

// ===== hw/rtl/rose_curve_segment_generator.sv =====
// Top level of the rose curve segment generator: registers, front, queue, back
//
//  channel | direction | handshake              | word
//  in      | input     | in_valid_i/in_stall_o  | rotation_i, restart_i
//  out     | output    | out_valid_o/out_stall_i| start_x/y_o, end_x/y_o, last_o
//  cfg     | input     | APB psel/penable       | paddr, pwdata, prdata
//
// In the back end, the time of a segment is set by the 38-step bit-serial
// divider, run once per endpoint, and the single shared CORDIC unit, run
// twice per endpoint.
// The front end takes a word per cycle, unless the two-entry queue is full.
// Reset is asynchronous, active low; registers return to their defaults.
// A stalled result holds in the output register while the next is computed.
module rose_curve_segment_generator #(
  parameter int unsigned ANGLE_FRACTION_BITS = 16,
  parameter int unsigned CORDIC_ITERATIONS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        rotation_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [11:0] start_x_o,
  output logic signed [11:0] start_y_o,
  output logic signed [11:0] end_x_o,
  output logic signed [11:0] end_y_o,
  output logic               last_o
);

  rcsg_pkg::cfg_t cfg_q;
  rcsg_pkg::seg_t push_data, pop_data;
  logic           push, pop, full, empty, wr;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.petal_n    <= rcsg_pkg::RST_PETAL_N;
      cfg_q.petal_d    <= rcsg_pkg::RST_PETAL_D;
      cfg_q.curve_size <= rcsg_pkg::RST_CURVE_SIZE;
      cfg_q.origin_x   <= rcsg_pkg::RST_ORIGIN_X;
      cfg_q.origin_y   <= rcsg_pkg::RST_ORIGIN_Y;
      cfg_q.step_turns <= rcsg_pkg::RST_STEP_TURNS;
    end else if (wr) begin
      unique case (idx)
        rcsg_pkg::REG_PETAL_N:    cfg_q.petal_n    <= pwdata[4:0];
        rcsg_pkg::REG_PETAL_D:    cfg_q.petal_d    <= pwdata[4:0];
        rcsg_pkg::REG_CURVE_SIZE: cfg_q.curve_size <= pwdata[9:0];
        rcsg_pkg::REG_ORIGIN_X:   cfg_q.origin_x   <= pwdata[9:0];
        rcsg_pkg::REG_ORIGIN_Y:   cfg_q.origin_y   <= pwdata[9:0];
        rcsg_pkg::REG_STEP_TURNS: cfg_q.step_turns <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      rcsg_pkg::REG_PETAL_N:    prdata = 32'(cfg_q.petal_n);
      rcsg_pkg::REG_PETAL_D:    prdata = 32'(cfg_q.petal_d);
      rcsg_pkg::REG_CURVE_SIZE: prdata = 32'(cfg_q.curve_size);
      rcsg_pkg::REG_ORIGIN_X:   prdata = 32'(cfg_q.origin_x);
      rcsg_pkg::REG_ORIGIN_Y:   prdata = 32'(cfg_q.origin_y);
      rcsg_pkg::REG_STEP_TURNS: prdata = 32'(cfg_q.step_turns);
      default:                  prdata = 32'd0;
    endcase
  end

  rcsg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rotation_i  (rotation_i),
    .restart_i   (restart_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rcsg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  rcsg_back #(
    .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS),
    .CORDIC_ITERATIONS   (CORDIC_ITERATIONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .entry_i     (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .start_x_o   (start_x_o),
    .start_y_o   (start_y_o),
    .end_x_o     (end_x_o),
    .end_y_o     (end_y_o),
    .last_o      (last_o)
  );

endmodule

// ===== hw/rtl/rcsg_checker.sv =====
// Port-level checker of the rose curve segment generator and its bind
`include "rose_curve_segment_generator_macros.svh"

module rcsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [11:0] start_x_o,
  input logic [11:0] start_y_o,
  input logic [11:0] end_x_o,
  input logic [11:0] end_y_o,
  input logic        last_o
);

  // a stalled result word holds
  `RCSG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(start_x_o) && $stable(start_y_o) && $stable(end_x_o) && $stable(end_y_o) && $stable(last_o))

  // the register port never waits
  `RCSG_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)

  // a written size reads back in the next cycle
  `RCSG_ASSERT_IMP(a_size_rb, clk_i, rst_ni, (psel && penable && pwrite && paddr == {rcsg_pkg::REG_CURVE_SIZE, 2'b00}) ##1 (psel && !pwrite && paddr == {rcsg_pkg::REG_CURVE_SIZE, 2'b00}), prdata == {22'd0, $past(pwdata[9:0])})

endmodule

bind rose_curve_segment_generator rcsg_checker u_rcsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .start_x_o   (start_x_o),
  .start_y_o   (start_y_o),
  .end_x_o     (end_x_o),
  .end_y_o     (end_y_o),
  .last_o      (last_o)
);

// ===== tb/tb_rose_curve_segment_generator.sv =====
// Testbench for the rose curve segment generator: directed and random segments
`timescale 1ns / 1ps

module tb_rose_curve_segment_generator;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam logic [2:0]  REG_UNUSED     = 3'd6;

  typedef struct packed {
    logic [11:0] sx;
    logic [11:0] sy;
    logic [11:0] ex;
    logic [11:0] ey;
    logic        last;
  } segment_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               in_valid_i, in_stall_o;
  logic [15:0]        rotation_i;
  logic               restart_i;
  logic               out_valid_o, out_stall_i;
  logic signed [11:0] start_x_o, start_y_o, end_x_o, end_y_o;
  logic               last_o;

  // predictor copy of registers and segment counter
  logic [4:0]  m_n, m_d;
  logic [9:0]  m_size, m_cx, m_cy;
  logic [19:0] m_step;
  logic [11:0] m_index;

  segment_t    seg_expected[$];
  int unsigned mismatches, segs_seen, lasts_seen, idle_cycles, hold_left;
  bit          send_gaps, stall_gaps;

  rose_curve_segment_generator u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Q30 CORDIC rounded to Q1.15, quadrant folded back at the end
  function automatic void sin_cos_q15(input logic [15:0] ang, output longint c_o,
                                      output longint s_o);
    logic [31:0] a, q;
    longint      x, y, z, dx, dy, c, s;
    a = {ang, 16'h0};
    q = ((a + 32'h2000_0000) >> 30) & 32'd3;
    z = longint'($signed(a - (q << 30)));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(rcsg_pkg::atan_q32(5'(i)));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(rcsg_pkg::atan_q32(5'(i)));
      end
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    case (q)
      0: begin c_o = c;  s_o = s;  end
      1: begin c_o = -s; s_o = c;  end
      2: begin c_o = -c; s_o = -s; end
      default: begin c_o = s; s_o = -c; end
    endcase
  endfunction

  // one curve point for segment boundary k
  function automatic void rose_pixel(input longint unsigned k, input logic [15:0] rot,
                                     output logic [11:0] px, output logic [11:0] py);
    longint unsigned dd, phase, ang;
    longint          rc, rs, c, s, ox, oy;
    dd    = (m_d == 0) ? 1 : m_d;
    phase = ((longint'(m_n) * k * m_step) / dd) & 64'hFFFF;
    ang   = (k * m_step + rot) & 64'hFFFF;
    sin_cos_q15(16'(phase), rc, rs);
    sin_cos_q15(16'(ang), c, s);
    ox = (rs * c * longint'(m_size) + (longint'(1) << 29)) >>> 30;
    oy = (rs * s * longint'(m_size) + (longint'(1) << 29)) >>> 30;
    px = 12'(longint'(m_cx) + ox);
    py = 12'(longint'(m_cy) + oy);
  endfunction

  // advance the segment counter and queue the expected segment
  function automatic void predict_segment(input logic [15:0] rot, input logic rs);
    longint unsigned dd, count, k;
    segment_t        e;
    dd    = (m_d == 0) ? 1 : m_d;
    count = ((dd * 64'd863554413089) >> 32) + 1;
    if (count > 4096) count = 4096;
    if (rs) m_index = '0;
    k = m_index;
    rose_pixel(k, rot, e.sx, e.sy);
    rose_pixel(k + 1, rot, e.ex, e.ey);
    e.last  = (k >= count - 1);
    m_index = e.last ? 12'd0 : 12'(k + 1);
    seg_expected.push_back(e);
  endfunction

  // register write, setup then access
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      rcsg_pkg::REG_PETAL_N:    m_n    = val[4:0];
      rcsg_pkg::REG_PETAL_D:    m_d    = val[4:0];
      rcsg_pkg::REG_CURVE_SIZE: m_size = val[9:0];
      rcsg_pkg::REG_ORIGIN_X:   m_cx   = val[9:0];
      rcsg_pkg::REG_ORIGIN_Y:   m_cy   = val[9:0];
      rcsg_pkg::REG_STEP_TURNS: m_step = val[19:0];
      default: ;
    endcase
  endtask

  // send one request word, with random gaps ahead of it
  task automatic send_word(input logic [15:0] rot, input logic rs);
    while (send_gaps && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rotation_i <= rot;
    restart_i  <= rs;
    do @(posedge clk_i); while (in_stall_o);
    predict_segment(rot, rs);
  endtask

  // stop offering and wait for every segment to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (seg_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_all(input logic [4:0] n, input logic [4:0] d, input logic [9:0] sz,
                           input logic [9:0] cx, input logic [9:0] cy, input logic [19:0] st);
    write_reg(rcsg_pkg::REG_PETAL_N, 32'(n));
    write_reg(rcsg_pkg::REG_PETAL_D, 32'(d));
    write_reg(rcsg_pkg::REG_CURVE_SIZE, 32'(sz));
    write_reg(rcsg_pkg::REG_ORIGIN_X, 32'(cx));
    write_reg(rcsg_pkg::REG_ORIGIN_Y, 32'(cy));
    write_reg(rcsg_pkg::REG_STEP_TURNS, 32'(st));
  endtask

  // reset defaults, restart and rotation extremes
  task automatic test_defaults();
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h4000, 1'b1);
    send_word(16'h8000, 1'b0);
    drain();
  endtask

  // register extremes and the corner cases of n and d
  task automatic test_extremes();
    write_all(5'd31, 5'd31, 10'd1023, 10'd1023, 10'd0, 20'hFFFFF);
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h5555, 1'b0);
    drain();
    write_all(5'd0, 5'd3, 10'd512, 10'd0, 10'd1023, 20'd1);
    send_word(16'h1234, 1'b0);
    send_word(16'hAAAA, 1'b0);
    drain();
    write_all(5'd16, 5'd0, 10'd0, 10'd100, 10'd100, 20'd4096);
    send_word(16'h0F0F, 1'b0);
    drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(rcsg_pkg::REG_CURVE_SIZE, 32'd1023);
    send_word(16'hF0F0, 1'b1);
    send_word(16'h0001, 1'b0);
    drain();
  endtask

  // a full pass at d = 1 wraps the counter
  task automatic test_pass_wrap();
    write_all(5'd5, 5'd1, 10'd300, 10'd320, 10'd240, 20'd73014);
    send_word(16'($urandom), 1'b1);
    repeat (209) send_word(16'($urandom), 1'b0);
    drain();
  endtask

  // shrinking d leaves the counter past the end of the pass
  task automatic test_shrink_d();
    write_reg(rcsg_pkg::REG_PETAL_D, 32'd2);
    send_word(16'($urandom), 1'b1);
    repeat (239) send_word(16'($urandom), 1'b0);
    drain();
    write_reg(rcsg_pkg::REG_PETAL_D, 32'd1);
    repeat (3) send_word(16'($urandom), 1'b0);
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_left = HOLD_CYCLES;
    repeat (12) send_word(16'($urandom), 1'b0);
    drain();
  endtask

  // random settings, mostly short passes, occasional restarts
  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      write_all(5'($urandom_range(31)), 5'(($urandom_range(3) == 0) ? $urandom_range(31)
                : $urandom_range(2)), 10'($urandom), 10'($urandom), 10'($urandom),
                20'($urandom_range(1, 20'hFFFFF)));
      send_gaps  = (ph != 2);
      stall_gaps = (ph != 2);
      repeat (50) send_word(16'($urandom), $urandom_range(99) < 4);
      drain();
    end
    send_gaps  = 1'b1;
    stall_gaps = 1'b1;
  endtask

  // result checker and output stall driver
  initial begin
    segment_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        segs_seen++;
        if (last_o) lasts_seen++;
        if (seg_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected segment at %0t", $time);
        end else begin
          e = seg_expected.pop_front();
          if (e.sx != start_x_o || e.sy != start_y_o || e.ex != end_x_o ||
              e.ey != end_y_o || e.last != last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t exp %0d,%0d %0d,%0d %0b got %0d,%0d %0d,%0d %0b",
                       $time, $signed(e.sx), $signed(e.sy), $signed(e.ex), $signed(e.ey),
                       e.last, start_x_o, start_y_o, end_x_o, end_y_o, last_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= stall_gaps && ($urandom_range(99) < 23);
      end
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("tb_rose_curve_segment_generator: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    rotation_i  = '0;
    restart_i   = 1'b0;
    out_stall_i = 1'b0;
    send_gaps   = 1'b1;
    stall_gaps  = 1'b1;
    m_n = 5'd1; m_d = 5'd1; m_size = 10'd256; m_cx = 10'd320; m_cy = 10'd240;
    m_step = 20'd73014; m_index = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_pass_wrap();
    test_shrink_d();
    test_backpressure();
    test_random();
    repeat (200) @(posedge clk_i);
    $display("covered %0d segments (%0d pass ends) over register extremes, n or d of zero,",
             segs_seen, lasts_seen);
    $display("full passes, counter past the end, long output hold-off and random settings");
    if (mismatches == 0 && seg_expected.size() == 0) begin
      $display("tb_rose_curve_segment_generator: PASS");
    end else begin
      $display("%0d mismatches, %0d segments missing", mismatches, seg_expected.size());
      $display("tb_rose_curve_segment_generator: FAIL");
    end
    $finish;
  end

endmodule
